// ===== design/url_unescape_utf8_decoder_unit_macros.svh =====
// Assertion macros used by the decoder's queue module.
`ifndef URL_UNESCAPE_UTF8_DECODER_UNIT_MACROS_SVH
`define URL_UNESCAPE_UTF8_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define UUD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define UUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/uud_pkg.sv =====
// Shared types and constants of the URL unescape decoder.
package uud_pkg;

    localparam int MAX_BEATS   = 4;
    localparam int N_W         = $clog2(MAX_BEATS + 1);
    localparam int IDX_W       = $clog2(MAX_BEATS);
    localparam int CAP_W       = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_PCT,
        MODE_PCT_H,
        MODE_PCT_U,
        MODE_BSL,
        MODE_BSL_X,
        MODE_BSL_X_H,
        MODE_CODE,
        MODE_CODE_ZERO,
        MODE_CODE_X
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_done;
    } out_item_t;

    typedef struct packed {
        logic [N_W-1:0]                n;
        logic [MAX_BEATS-1:0][7:0]     slot;
        logic                          done;
    } bundle_t;

endpackage

// ===== design/uud_front.sv =====
// Front end: accepts input beats, runs the escape scanner and forms result bundles.
module uud_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  uud_pkg::in_item_t            in_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [uud_pkg::CAP_W-1:0]    cfg_data,
    output logic                         push,
    output uud_pkg::bundle_t             push_data,
    input  logic                         full
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U_LO  = 8'h75;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [11:0] CODE_DEL = 12'h07F;
    localparam logic [15:0] CODE_BIG = 16'h0800;
    localparam logic [uud_pkg::N_W-1:0] N_MAX = uud_pkg::N_W'(uud_pkg::MAX_BEATS);

    typedef struct packed {
        uud_pkg::mode_t                      mode;
        logic [2:0][7:0]                     held;
        logic [1:0]                          hcnt;
        logic [11:0]                         code;
        logic                                big;
        logic [uud_pkg::CAP_W-1:0]           cnt;
        logic                                halted;
        logic [uud_pkg::N_W-1:0]             n;
        logic [uud_pkg::MAX_BEATS-1:0][7:0]  slot;
    } work_t;

    function automatic logic [4:0] hex_of(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, b[3:0]};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic work_t put_byte(work_t w, logic [7:0] b);
        work_t r;
        r = w;
        if (w.n < N_MAX)
        begin
            r.slot[w.n[uud_pkg::IDX_W-1:0]] = b;
            r.n = w.n + uud_pkg::N_W'(1);
        end
        r.cnt = w.cnt + uud_pkg::CAP_W'(1);
        return r;
    endfunction

    function automatic work_t start_token(work_t w, logic [7:0] b,
                                          logic [uud_pkg::CAP_W-1:0] lim);
        work_t r;
        r = w;
        if (!w.halted)
        begin
            if (w.cnt >= lim)
            begin
                r.halted = 1'b1;
                r.mode   = uud_pkg::MODE_IDLE;
                r.hcnt   = 2'd0;
            end
            else if (b == CH_PLUS)
            begin
                r = put_byte(w, CH_SPACE);
            end
            else if (b == CH_PCT)
            begin
                r.held[0] = b;
                r.hcnt    = 2'd1;
                r.mode    = uud_pkg::MODE_PCT;
            end
            else if (b == CH_BSL)
            begin
                r.held[0] = b;
                r.hcnt    = 2'd1;
                r.mode    = uud_pkg::MODE_BSL;
            end
            else
            begin
                r = put_byte(w, b);
            end
        end
        return r;
    endfunction

    function automatic work_t drop_held(work_t w, logic [uud_pkg::CAP_W-1:0] lim);
        work_t           r;
        logic [2:0][7:0] c;
        logic [1:0]      n0;
        r      = w;
        c      = w.held;
        n0     = w.hcnt;
        r.mode = uud_pkg::MODE_IDLE;
        r.hcnt = 2'd0;
        if (n0 != 2'd0)
        begin
            r = put_byte(r, c[0]);
            if (n0 > 2'd1)
            begin
                r = start_token(r, c[1], lim);
            end
            if (n0 > 2'd2)
            begin
                r = start_token(r, c[2], lim);
            end
        end
        return r;
    endfunction

    function automatic work_t finish_code(work_t w);
        work_t r;
        r = w;
        if (!w.big)
        begin
            if (w.code > CODE_DEL)
            begin
                r = put_byte(r, 8'hC0 | {2'b00, w.code[11:6]});
                r = put_byte(r, {2'b10, w.code[5:0]});
            end
            else if (w.code < CODE_DEL)
            begin
                r = put_byte(r, w.code[7:0]);
            end
        end
        r.mode = uud_pkg::MODE_IDLE;
        r.hcnt = 2'd0;
        r.code = 12'd0;
        r.big  = 1'b0;
        return r;
    endfunction

    function automatic work_t take_digit(work_t w, logic [3:0] d);
        work_t       r;
        logic [15:0] v;
        r = w;
        v = {w.code, d};
        if (!w.big)
        begin
            if (v >= CODE_BIG)
            begin
                r.big = 1'b1;
            end
            else
            begin
                r.code = v[11:0];
            end
        end
        return r;
    endfunction

    function automatic work_t feed(work_t w, logic [7:0] b,
                                   logic [uud_pkg::CAP_W-1:0] lim);
        work_t      r;
        logic [4:0] hx;
        logic [4:0] hi;
        logic [7:0] x;
        r  = w;
        hx = hex_of(b);
        hi = 5'd0;
        x  = w.held[0];
        case (w.mode)
            uud_pkg::MODE_PCT:
            begin
                if (hx[4] || b == CH_U_LO)
                begin
                    r.held[1] = b;
                    r.hcnt    = 2'd2;
                    r.mode    = hx[4] ? uud_pkg::MODE_PCT_H : uud_pkg::MODE_PCT_U;
                end
                else
                begin
                    r = drop_held(r, lim);
                    r = start_token(r, b, lim);
                end
            end
            uud_pkg::MODE_PCT_H, uud_pkg::MODE_BSL_X_H:
            begin
                if (hx[4])
                begin
                    hi     = hex_of((w.mode == uud_pkg::MODE_PCT_H) ? w.held[1] : w.held[2]);
                    r      = put_byte(r, {hi[3:0], hx[3:0]});
                    r.mode = uud_pkg::MODE_IDLE;
                    r.hcnt = 2'd0;
                end
                else
                begin
                    r = drop_held(r, lim);
                    r = start_token(r, b, lim);
                end
            end
            uud_pkg::MODE_PCT_U:
            begin
                if (hx[4])
                begin
                    r.code = {8'd0, hx[3:0]};
                    r.big  = 1'b0;
                    r.hcnt = 2'd0;
                    r.mode = (b == CH_ZERO) ? uud_pkg::MODE_CODE_ZERO : uud_pkg::MODE_CODE;
                end
                else
                begin
                    r = drop_held(r, lim);
                    r = start_token(r, b, lim);
                end
            end
            uud_pkg::MODE_BSL:
            begin
                if (b == CH_X_LO)
                begin
                    r.held[1] = b;
                    r.hcnt    = 2'd2;
                    r.mode    = uud_pkg::MODE_BSL_X;
                end
                else
                begin
                    r = drop_held(r, lim);
                    r = start_token(r, b, lim);
                end
            end
            uud_pkg::MODE_BSL_X:
            begin
                if (hx[4])
                begin
                    r.held[2] = b;
                    r.hcnt    = 2'd3;
                    r.mode    = uud_pkg::MODE_BSL_X_H;
                end
                else
                begin
                    r = drop_held(r, lim);
                    r = start_token(r, b, lim);
                end
            end
            uud_pkg::MODE_CODE_ZERO:
            begin
                if (b == CH_X_LO || b == CH_X_UP)
                begin
                    r.held[0] = b;
                    r.hcnt    = 2'd1;
                    r.mode    = uud_pkg::MODE_CODE_X;
                end
                else if (hx[4])
                begin
                    r      = take_digit(r, hx[3:0]);
                    r.mode = uud_pkg::MODE_CODE;
                end
                else
                begin
                    r = finish_code(r);
                    r = start_token(r, b, lim);
                end
            end
            uud_pkg::MODE_CODE:
            begin
                if (hx[4])
                begin
                    r = take_digit(r, hx[3:0]);
                end
                else
                begin
                    r = finish_code(r);
                    r = start_token(r, b, lim);
                end
            end
            uud_pkg::MODE_CODE_X:
            begin
                if (hx[4])
                begin
                    r.code = {8'd0, hx[3:0]};
                    r.big  = 1'b0;
                    r.hcnt = 2'd0;
                    r.mode = uud_pkg::MODE_CODE;
                end
                else
                begin
                    r = finish_code(r);
                    r = start_token(r, x, lim);
                    r = start_token(r, b, lim);
                end
            end
            default:
            begin
                r.mode = uud_pkg::MODE_IDLE;
                r.hcnt = 2'd0;
                r      = start_token(r, b, lim);
            end
        endcase
        return r;
    endfunction

    function automatic work_t end_string(work_t w, logic [uud_pkg::CAP_W-1:0] lim);
        work_t      r;
        logic [7:0] x;
        r = w;
        x = w.held[0];
        case (w.mode)
            uud_pkg::MODE_PCT, uud_pkg::MODE_PCT_H, uud_pkg::MODE_PCT_U,
            uud_pkg::MODE_BSL, uud_pkg::MODE_BSL_X, uud_pkg::MODE_BSL_X_H:
            begin
                r = drop_held(r, lim);
            end
            uud_pkg::MODE_CODE, uud_pkg::MODE_CODE_ZERO:
            begin
                r = finish_code(r);
            end
            uud_pkg::MODE_CODE_X:
            begin
                r = finish_code(r);
                r = start_token(r, x, lim);
            end
            default:
            begin
                r = w;
            end
        endcase
        r.mode   = uud_pkg::MODE_IDLE;
        r.hcnt   = 2'd0;
        r.code   = 12'd0;
        r.big    = 1'b0;
        r.cnt    = '0;
        r.halted = 1'b0;
        return r;
    endfunction

    logic [uud_pkg::CAP_W-1:0] cap_reg;
    logic [uud_pkg::CAP_W-1:0] cap_next;
    uud_pkg::mode_t            mode_reg;
    uud_pkg::mode_t            mode_next;
    logic [2:0][7:0]           held_reg;
    logic [2:0][7:0]           held_next;
    logic [1:0]                hcnt_reg;
    logic [1:0]                hcnt_next;
    logic [11:0]               code_reg;
    logic [11:0]               code_next;
    logic                      big_reg;
    logic                      big_next;
    logic [uud_pkg::CAP_W-1:0] cnt_reg;
    logic [uud_pkg::CAP_W-1:0] cnt_next;
    logic                      halted_reg;
    logic                      halted_next;

    logic [uud_pkg::CAP_W-1:0] limit;
    logic                      accept;
    work_t                     cur;
    work_t                     step;
    logic                      step_done;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;
    assign limit     = (cap_reg >= uud_pkg::CAP_W'(2)) ? cap_reg - uud_pkg::CAP_W'(2) : '0;
    assign cap_next  = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;

    always_comb
    begin
        cur.mode   = mode_reg;
        cur.held   = held_reg;
        cur.hcnt   = hcnt_reg;
        cur.code   = code_reg;
        cur.big    = big_reg;
        cur.cnt    = cnt_reg;
        cur.halted = halted_reg;
        cur.n      = '0;
        cur.slot   = '0;
        if (in_data.in_byte == CH_NUL)
        begin
            step      = end_string(cur, limit);
            step_done = 1'b1;
        end
        else
        begin
            step      = feed(cur, in_data.in_byte, limit);
            step_done = in_data.in_last;
            if (in_data.in_last)
            begin
                step = end_string(step, limit);
            end
        end
    end

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        hcnt_next   = hcnt_reg;
        code_next   = code_reg;
        big_next    = big_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        if (accept)
        begin
            mode_next   = step.mode;
            held_next   = step.held;
            hcnt_next   = step.hcnt;
            code_next   = step.code;
            big_next    = step.big;
            cnt_next    = step.cnt;
            halted_next = step.halted;
        end
    end

    // outputs
    always_comb
    begin
        push_data.n    = step.n;
        push_data.slot = step.slot;
        push_data.done = step_done;
        push           = accept && (step.n != '0 || step_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= uud_pkg::CAP_RESET;
            mode_reg   <= uud_pkg::MODE_IDLE;
            hcnt_reg   <= 2'd0;
            code_reg   <= 12'd0;
            big_reg    <= 1'b0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            cap_reg    <= cap_next;
            mode_reg   <= mode_next;
            hcnt_reg   <= hcnt_next;
            code_reg   <= code_next;
            big_reg    <= big_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// ===== design/uud_queue.sv =====
// Bundle queue between the scanner front end and the beat back end.
`include "url_unescape_utf8_decoder_unit_macros.svh"

module uud_queue #(
    parameter int DEPTH = uud_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  uud_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output uud_pkg::bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uud_pkg::bundle_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push_ok;
    logic               pop_ok;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign pop_ok     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `UUD_ASSERT_IMPL(a_push_room, clk, rst_n, push, !full, "bundle pushed into a full queue")
    `UUD_ASSERT_IMPL(a_pop_data, clk, rst_n, pop, head_valid, "pop from an empty queue")
    `UUD_ASSERT_NEXT(a_count_up, clk, rst_n, push_ok && !pop_ok, count_reg == $past(count_reg) + CNT_W'(1), "queue count missed a push")
    `UUD_ASSERT_NEXT(a_count_down, clk, rst_n, pop_ok && !push_ok, count_reg == $past(count_reg) - CNT_W'(1), "queue count missed a pop")

endmodule

// ===== design/uud_back.sv =====
// Back end: splits each bundle into result beats behind an output register.
module uud_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  uud_pkg::bundle_t   head,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output uud_pkg::out_item_t res_data
);

    logic [uud_pkg::IDX_W-1:0] idx_reg;
    logic [uud_pkg::IDX_W-1:0] idx_next;
    uud_pkg::out_item_t        res_reg;
    uud_pkg::out_item_t        res_next;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    uud_pkg::out_item_t        beat;
    logic                      beat_last;
    logic                      load;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign load      = head_valid && (!res_valid_reg || !res_stall);
    assign pop       = load && beat_last;

    always_comb
    begin
        beat_last      = (head.n == '0)
                         || ({1'b0, idx_reg} == head.n - uud_pkg::N_W'(1));
        beat.out_valid = head.n != '0;
        beat.out_byte  = (head.n == '0) ? 8'h00 : head.slot[idx_reg];
        beat.out_done  = head.done && beat_last;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_next       = beat;
            res_valid_next = 1'b1;
            idx_next       = beat_last ? '0 : idx_reg + uud_pkg::IDX_W'(1);
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== design/url_unescape_utf8_decoder_unit.sv =====
// Top level of the URL unescape decoder with %u to UTF-8 conversion.
// The decoder takes one string byte per cycle and, as long as each byte yields at most
// one decoded byte and res_stall is low, returns one result beat per cycle; each beat
// is registered in the queue and then in the output register. A byte that finishes an
// escape may yield up to four beats; these drain from the output register one per
// cycle while the front end keeps taking bytes into a queue of QUEUE_DEPTH bundles,
// and in_stall rises only when that queue is full. The scanner decides every byte
// combinationally, so the output beat rate is what bounds throughput. A string ends
// on a zero byte or on in_last; its final beat carries out_done, with out_valid low
// if nothing was left to emit. The user writes output_capacity on the cfg port only
// while no string is in flight; the block itself does not enforce this.
module url_unescape_utf8_decoder_unit #(
    parameter int QUEUE_DEPTH = uud_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  uud_pkg::in_item_t         in_data,
    output logic                      res_valid,
    input  logic                      res_stall,
    output uud_pkg::out_item_t        res_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [uud_pkg::CAP_W-1:0] cfg_data
);

    logic             push;
    uud_pkg::bundle_t push_data;
    logic             full;
    logic             pop;
    logic             head_valid;
    uud_pkg::bundle_t head;

    uud_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    uud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    uud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

// ===== tb/sv/tb_url_unescape_utf8_decoder_unit.sv =====
// Testbench for the URL unescape decoder: directed and random strings checked beat by beat.
module tb_url_unescape_utf8_decoder_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_XU    = 8'h58;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    uud_pkg::in_item_t         in_data;
    logic                      res_valid;
    logic                      res_stall;
    uud_pkg::out_item_t        res_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [uud_pkg::CAP_W-1:0] cfg_data;

    uud_pkg::in_item_t         tx_items[$];
    uud_pkg::out_item_t        decoded_beats[$];
    logic [7:0]                step_out[$];

    int                        n_sent;
    int                        n_taken;
    int                        n_cfg;
    int                        fails;
    int                        cycles;
    bit                        in_taken;
    bit                        steady;

    logic [uud_pkg::CAP_W-1:0] cap_reg;
    uud_pkg::mode_t            scan;
    logic [7:0]                esc_hold [3];
    int unsigned               esc_len;
    int unsigned               code_val;
    bit                        code_big;
    logic [15:0]               emitted_cnt;
    bit                        halt;

    url_unescape_utf8_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] d);
        d = 4'd0;
        if (b >= "0" && b <= "9")
        begin
            d = 4'(b - "0");
            return 1'b1;
        end
        if (b >= "a" && b <= "f")
        begin
            d = 4'(b - "a" + 10);
            return 1'b1;
        end
        if (b >= "A" && b <= "F")
        begin
            d = 4'(b - "A" + 10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void put_out(logic [7:0] b);
        if (step_out.size() < uud_pkg::MAX_BEATS)
            step_out = {step_out, b};
        emitted_cnt = emitted_cnt + 16'd1;
    endfunction

    function automatic void begin_token(logic [7:0] b);
        int unsigned lim;
        lim = (cap_reg >= 2) ? cap_reg - 2 : 0;
        if (halt)
            return;
        if (emitted_cnt >= lim)
        begin
            halt = 1'b1;
            scan = uud_pkg::MODE_IDLE;
            esc_len = 0;
            return;
        end
        if (b == CH_PLUS)
            put_out(CH_SPACE);
        else if (b == CH_PCT)
        begin
            esc_hold[0] = b;
            esc_len = 1;
            scan = uud_pkg::MODE_PCT;
        end
        else if (b == CH_BSL)
        begin
            esc_hold[0] = b;
            esc_len = 1;
            scan = uud_pkg::MODE_BSL;
        end
        else
            put_out(b);
    endfunction

    function automatic void flush_held();
        logic [7:0] copy [3];
        int unsigned n;
        n = (esc_len > 3) ? 3 : esc_len;
        copy = esc_hold;
        scan = uud_pkg::MODE_IDLE;
        esc_len = 0;
        if (n == 0)
            return;
        put_out(copy[0]);
        for (int i = 1; i < n; i++)
            begin_token(copy[i]);
    endfunction

    function automatic void close_code();
        if (!code_big)
        begin
            if (code_val > 'h7F)
            begin
                put_out(8'((code_val >> 6) | 'hC0));
                put_out(8'((code_val & 'h3F) | 'h80));
            end
            else if (code_val < 'h7F)
                put_out(8'(code_val));
        end
        scan = uud_pkg::MODE_IDLE;
        esc_len = 0;
        code_val = 0;
        code_big = 1'b0;
    endfunction

    function automatic void add_digit(logic [3:0] d);
        int unsigned v;
        if (code_big)
            return;
        v = code_val * 16 + d;
        if (v >= 'h800)
            code_big = 1'b1;
        else
            code_val = v;
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        logic [3:0] d;
        logic [3:0] hi;
        logic [7:0] x;
        bit         hx;
        hx = hex_digit(b, d);
        case (scan)
            uud_pkg::MODE_PCT:
                if (hx)
                begin
                    esc_hold[1] = b;
                    esc_len = 2;
                    scan = uud_pkg::MODE_PCT_H;
                end
                else if (b == CH_U)
                begin
                    esc_hold[1] = b;
                    esc_len = 2;
                    scan = uud_pkg::MODE_PCT_U;
                end
                else
                begin
                    flush_held();
                    begin_token(b);
                end
            uud_pkg::MODE_PCT_H:
                if (hx)
                begin
                    void'(hex_digit(esc_hold[1], hi));
                    put_out({hi, d});
                    scan = uud_pkg::MODE_IDLE;
                    esc_len = 0;
                end
                else
                begin
                    flush_held();
                    begin_token(b);
                end
            uud_pkg::MODE_PCT_U:
                if (hx)
                begin
                    code_val = d;
                    code_big = 1'b0;
                    esc_len = 0;
                    scan = (b == CH_ZERO) ? uud_pkg::MODE_CODE_ZERO : uud_pkg::MODE_CODE;
                end
                else
                begin
                    flush_held();
                    begin_token(b);
                end
            uud_pkg::MODE_BSL:
                if (b == CH_X)
                begin
                    esc_hold[1] = b;
                    esc_len = 2;
                    scan = uud_pkg::MODE_BSL_X;
                end
                else
                begin
                    flush_held();
                    begin_token(b);
                end
            uud_pkg::MODE_BSL_X:
                if (hx)
                begin
                    esc_hold[2] = b;
                    esc_len = 3;
                    scan = uud_pkg::MODE_BSL_X_H;
                end
                else
                begin
                    flush_held();
                    begin_token(b);
                end
            uud_pkg::MODE_BSL_X_H:
                if (hx)
                begin
                    void'(hex_digit(esc_hold[2], hi));
                    put_out({hi, d});
                    scan = uud_pkg::MODE_IDLE;
                    esc_len = 0;
                end
                else
                begin
                    flush_held();
                    begin_token(b);
                end
            uud_pkg::MODE_CODE_ZERO:
                if (b == CH_X || b == CH_XU)
                begin
                    esc_hold[0] = b;
                    esc_len = 1;
                    scan = uud_pkg::MODE_CODE_X;
                end
                else if (hx)
                begin
                    add_digit(d);
                    scan = uud_pkg::MODE_CODE;
                end
                else
                begin
                    close_code();
                    begin_token(b);
                end
            uud_pkg::MODE_CODE:
                if (hx)
                    add_digit(d);
                else
                begin
                    close_code();
                    begin_token(b);
                end
            uud_pkg::MODE_CODE_X:
                if (hx)
                begin
                    code_val = d;
                    code_big = 1'b0;
                    esc_len = 0;
                    scan = uud_pkg::MODE_CODE;
                end
                else
                begin
                    x = esc_hold[0];
                    close_code();
                    begin_token(x);
                    begin_token(b);
                end
            default:
            begin
                scan = uud_pkg::MODE_IDLE;
                esc_len = 0;
                begin_token(b);
            end
        endcase
    endfunction

    function automatic void end_of_string();
        logic [7:0] x;
        case (scan)
            uud_pkg::MODE_PCT, uud_pkg::MODE_PCT_H, uud_pkg::MODE_PCT_U,
            uud_pkg::MODE_BSL, uud_pkg::MODE_BSL_X, uud_pkg::MODE_BSL_X_H:
                flush_held();
            uud_pkg::MODE_CODE, uud_pkg::MODE_CODE_ZERO:
                close_code();
            uud_pkg::MODE_CODE_X:
            begin
                x = esc_hold[0];
                close_code();
                begin_token(x);
            end
            default:
                ;
        endcase
        scan = uud_pkg::MODE_IDLE;
        esc_len = 0;
        code_val = 0;
        code_big = 1'b0;
        emitted_cnt = 16'd0;
        halt = 1'b0;
    endfunction

    function automatic void decode_byte(uud_pkg::in_item_t it);
        uud_pkg::out_item_t beat;
        bit                 ends;
        step_out.delete();
        ends = (it.in_byte == CH_NUL) || it.in_last;
        if (it.in_byte != CH_NUL)
            scan_byte(it.in_byte);
        if (ends)
            end_of_string();
        if (step_out.size() == 0)
        begin
            if (ends)
            begin
                beat.out_byte = 8'h00;
                beat.out_valid = 1'b0;
                beat.out_done = 1'b1;
                decoded_beats = {decoded_beats, beat};
            end
        end
        else
            foreach (step_out[k])
            begin
                beat.out_byte = step_out[k];
                beat.out_valid = 1'b1;
                beat.out_done = ends && (k == step_out.size() - 1);
                decoded_beats = {decoded_beats, beat};
            end
    endfunction

    function automatic bit rest_now();
        return !steady && ($urandom_range(0, 99) < 32);
    endfunction

    function automatic void put_ch(logic [7:0] b, logic last);
        uud_pkg::in_item_t it;
        it.in_byte = b;
        it.in_last = last;
        tx_items = {tx_items, it};
        n_sent++;
    endfunction

    function automatic void put_text(string s, bit last);
        for (int i = 0; i < s.len(); i++)
            put_ch(s[i], last && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] rand_hex();
        string digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic void gen_string();
        logic [7:0] txt[$];
        int         pieces;
        int         ndig;
        pieces = $urandom_range(1, 6);
        repeat (pieces)
        begin
            case ($urandom_range(0, 11))
                0:
                    txt = {txt, CH_PLUS};
                1, 2:
                    txt = {txt, CH_PCT, rand_hex(), rand_hex()};
                3:
                    txt = {txt, CH_BSL, CH_X, rand_hex(), rand_hex()};
                4, 5, 7:
                begin
                    txt = {txt, CH_PCT, CH_U};
                    ndig = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                    if ($urandom_range(0, 3) == 0)
                        ndig = $urandom_range(4, 6);
                    repeat (ndig)
                        txt = {txt, rand_hex()};
                end
                6:
                begin
                    txt = {txt, CH_PCT, CH_U, CH_ZERO};
                    txt = {txt, ($urandom_range(0, 1) ? CH_X : CH_XU)};
                    repeat ($urandom_range(0, 3))
                        txt = {txt, rand_hex()};
                end
                8:
                begin
                    case ($urandom_range(0, 5))
                        0: txt = {txt, CH_PCT};
                        1: txt = {txt, CH_PCT, rand_hex()};
                        2: txt = {txt, CH_PCT, CH_U};
                        3: txt = {txt, CH_BSL};
                        4: txt = {txt, CH_BSL, CH_X};
                        default:
                            txt = {txt, CH_BSL, CH_X, rand_hex()};
                    endcase
                    txt = {txt, 8'($urandom_range(0, 255))};
                end
                9:
                    txt = {txt, 8'($urandom_range(0, 255))};
                default:
                    txt = {txt, 8'($urandom_range(8'h20, 8'h7E))};
            endcase
        end
        if ($urandom_range(0, 2) != 0)
        begin
            foreach (txt[i])
                put_ch(txt[i], i == txt.size() - 1);
        end
        else
        begin
            foreach (txt[i])
                put_ch(txt[i], 1'b0);
            put_ch(CH_NUL, 1'($urandom_range(0, 1)));
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (n_taken != n_sent || decoded_beats.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_capacity(logic [uud_pkg::CAP_W-1:0] v);
        int target;
        target = n_cfg + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (n_cfg != target);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // drive: hold a stalled beat, advance after acceptance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (tx_items.size() != 0 && !rest_now())
                begin
                    in_data  <= tx_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            res_stall <= rest_now();
        end
    end

    always @(posedge clk)
    begin
        uud_pkg::out_item_t want;
        if (rst_n)
        begin
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                n_taken++;
                decode_byte(in_data);
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg = cfg_data;
                n_cfg++;
            end
            if (res_valid && !res_stall)
            begin
                if (decoded_beats.size() == 0)
                begin
                    $error("unexpected beat: out_byte %0h out_valid %0b out_done %0b",
                           res_data.out_byte, res_data.out_valid, res_data.out_done);
                    fails++;
                end
                else
                begin
                    want = decoded_beats.pop_front();
                    if (res_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte expected %0h actual %0h",
                               want.out_byte, res_data.out_byte);
                        fails++;
                    end
                    if (res_data.out_valid !== want.out_valid)
                    begin
                        $error("out_valid expected %0b actual %0b",
                               want.out_valid, res_data.out_valid);
                        fails++;
                    end
                    if (res_data.out_done !== want.out_done)
                    begin
                        $error("out_done expected %0b actual %0b",
                               want.out_done, res_data.out_done);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin
        logic [uud_pkg::CAP_W-1:0] caps [7];
        int                        goal;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        res_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_taken    = 1'b0;
        steady      = 1'b0;
        n_sent      = 0;
        n_taken     = 0;
        n_cfg       = 0;
        fails       = 0;
        cap_reg     = uud_pkg::CAP_RESET;
        scan        = uud_pkg::MODE_IDLE;
        esc_hold    = '{default: 8'h00};
        esc_len     = 0;
        code_val    = 0;
        code_big    = 1'b0;
        emitted_cnt = 16'd0;
        halt        = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        put_text("+%4a\\x5A%uE9%u7F%G", 1'b0);
        put_ch(CH_NUL, 1'b0);
        put_text("%u0x", 1'b1);
        put_ch(8'hFF, 1'b1);
        put_ch(CH_NUL, 1'b1);
        wait_drained();

        set_capacity(16'd3);
        put_text("%u7FFab", 1'b1);
        wait_drained();

        caps = '{16'd65535, 16'd1024, 16'd3, 16'($urandom_range(4, 12)),
                 16'($urandom_range(13, 60)), 16'd65535, 16'd200};
        foreach (caps[p])
        begin
            set_capacity(caps[p]);
            steady = (p == 5);
            goal = n_sent + PHASE_ITEMS;
            while (n_sent < goal)
                gen_string();
            wait_drained();
        end

        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
